// ===== src/sa_pkg.sv =====
package sa_pkg;

    localparam int MaxLen  = 4096;
    localparam int Alpha   = 27;
    localparam int NodeCap = 2 * MaxLen;
    localparam int IdxW    = $clog2(NodeCap);
    localparam int SymW    = 5;
    localparam int CntW    = $clog2(MaxLen + 1);
    localparam int TransW  = Alpha * IdxW;
    localparam int LenLo   = TransW;
    localparam int LinkLo  = TransW + IdxW;
    localparam int RowW    = TransW + 2 * IdxW;
    localparam int OutW    = 72;

    typedef logic [IdxW-1:0] idx_t;
    typedef logic [RowW-1:0] row_t;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_W1_RD  = 10'b0000000100,
        S_W1_CHK = 10'b0000001000,
        S_Q_CHK  = 10'b0000010000,
        S_Q_WR   = 10'b0000100000,
        S_W2_RD  = 10'b0001000000,
        S_W2_CHK = 10'b0010000000,
        S_FIN    = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    typedef struct packed {
        logic full_res;
        idx_t state_count;
        idx_t clone_state;
        logic cloned;
        idx_t link_state;
        idx_t new_length;
        idx_t new_state;
    } res_t;

    function automatic idx_t get_trans(input row_t row, input logic [SymW-1:0] c);
        return row[c*IdxW +: IdxW];
    endfunction

    function automatic row_t set_trans(input row_t row, input logic [SymW-1:0] c,
                                       input idx_t v);
        row_t r;
        r = row;
        r[c*IdxW +: IdxW] = v;
        return r;
    endfunction

    function automatic idx_t get_len(input row_t row);
        return row[LenLo +: IdxW];
    endfunction

    function automatic idx_t get_link(input row_t row);
        return row[LinkLo +: IdxW];
    endfunction

endpackage

// ===== src/sa_ram.sv =====
module sa_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/suffix_automaton_append.sv =====
// Channel  | Dir | Transfer carries
// s_*      | in  | s_tdata[4:0] symbol
// m_*      | out | result: new_state, new_length, link_state, cloned, clone_state,
//          |     |         state_count, full_res
//
// Memory: one row memory (8192 rows of transitions, length, link), one read and one
// write port. A rejected symbol goes straight to the output; a taken one checks the rows
// on the suffix-link walk, then checks q if it stops on a present transition, and on a
// clone then checks the rows on the clone's redirect walk.
// Reset: a clearing pass zeroes all 8192 rows, one a cycle, before the first transfer.
// Stalls: a result holds in the output register while the next symbol is worked on.
module suffix_automaton_append (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] symbol
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // new_state, new_length, link_state, cloned,
                                   // clone_state, state_count, full_res
);

    localparam int IdxW = sa_pkg::IdxW;

    sa_pkg::state_t state_reg, state_next;
    sa_pkg::idx_t clr_reg, clr_next;
    sa_pkg::idx_t last_reg, last_next;
    sa_pkg::idx_t count_reg, count_next;
    logic [sa_pkg::CntW-1:0] taken_reg, taken_next;
    sa_pkg::idx_t pre_reg, pre_next;
    sa_pkg::idx_t cur_reg, cur_next;
    sa_pkg::idx_t q_reg, q_next;
    sa_pkg::idx_t clone_reg, clone_next;
    sa_pkg::idx_t curlen_reg, curlen_next;
    sa_pkg::idx_t plen_reg, plen_next;
    sa_pkg::idx_t linkcur_reg, linkcur_next;
    logic [sa_pkg::SymW-1:0] sym_reg, sym_next;
    logic first_reg, first_next;
    logic made_reg, made_next;
    sa_pkg::row_t qrow_reg, qrow_next;
    sa_pkg::res_t pend_reg, pend_next;
    sa_pkg::res_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic we;
    sa_pkg::idx_t waddr, raddr, tr;
    sa_pkg::row_t wdata, rdata;
    logic accept, is_full;
    logic [IdxW:0] count_plus2;

    sa_ram #(.Width(sa_pkg::RowW), .Depth(sa_pkg::NodeCap)) u_rows (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign s_tready = (state_reg == sa_pkg::S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(sa_pkg::OutW - $bits(sa_pkg::res_t)){1'b0}}, out_reg};
    assign tr       = sa_pkg::get_trans(rdata, sym_reg);
    assign count_plus2 = {1'b0, count_reg} + (IdxW+1)'(2);
    assign is_full  = (taken_reg >= sa_pkg::CntW'(sa_pkg::MaxLen))
                   || (count_plus2 > (IdxW+1)'(sa_pkg::NodeCap));

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        taken_next   = taken_reg;
        pre_next     = pre_reg;
        cur_next     = cur_reg;
        q_next       = q_reg;
        clone_next   = clone_reg;
        curlen_next  = curlen_reg;
        plen_next    = plen_reg;
        linkcur_next = linkcur_reg;
        sym_next     = sym_reg;
        first_next   = first_reg;
        made_next    = made_reg;
        qrow_next    = qrow_reg;
        pend_next    = pend_reg;
        out_next     = out_reg;
        out_valid_next = out_valid_reg;
        we    = 1'b0;
        waddr = pre_reg;
        wdata = rdata;
        raddr = pre_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            sa_pkg::S_CLEAR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == sa_pkg::idx_t'(sa_pkg::NodeCap - 1))
                begin
                    state_next = sa_pkg::S_IDLE;
                end
            end
            sa_pkg::S_IDLE:
            begin
                raddr = last_reg;
                if (accept)
                begin
                    pend_next = '0;
                    pend_next.state_count = count_reg;
                    if (is_full)
                    begin
                        pend_next.full_res = 1'b1;
                        state_next = sa_pkg::S_OUT;
                    end
                    else if (s_tdata[4:0] >= sa_pkg::SymW'(sa_pkg::Alpha))
                    begin
                        state_next = sa_pkg::S_OUT;
                    end
                    else
                    begin
                        // start the walk at the old last state
                        sym_next   = s_tdata[4:0];
                        taken_next = taken_reg + 1'b1;
                        pre_next   = last_reg;
                        cur_next   = count_reg + 1'b1;
                        count_next = count_reg + 1'b1;
                        last_next  = count_reg + 1'b1;
                        first_next = 1'b1;
                        made_next  = 1'b0;
                        clone_next = '0;
                        state_next = sa_pkg::S_W1_CHK;
                    end
                end
            end
            sa_pkg::S_W1_RD:
            begin
                raddr      = pre_reg;
                state_next = sa_pkg::S_W1_CHK;
            end
            sa_pkg::S_W1_CHK:
            begin
                first_next = 1'b0;
                if (first_reg)
                begin
                    curlen_next = sa_pkg::get_len(rdata) + 1'b1;
                end
                if (tr == '0)
                begin
                    // fill the missing transition and follow the link
                    we       = 1'b1;
                    waddr    = pre_reg;
                    wdata    = sa_pkg::set_trans(rdata, sym_reg, cur_reg);
                    pre_next = sa_pkg::get_link(rdata);
                    if (sa_pkg::get_link(rdata) == '0)
                    begin
                        linkcur_next = sa_pkg::idx_t'(1);
                        state_next   = sa_pkg::S_FIN;
                    end
                    else
                    begin
                        state_next = sa_pkg::S_W1_RD;
                    end
                end
                else
                begin
                    q_next     = tr;
                    plen_next  = sa_pkg::get_len(rdata);
                    raddr      = tr;
                    state_next = sa_pkg::S_Q_CHK;
                end
            end
            sa_pkg::S_Q_CHK:
            begin
                if (sa_pkg::get_len(rdata) == plen_reg + 1'b1)
                begin
                    linkcur_next = q_reg;
                    state_next   = sa_pkg::S_FIN;
                end
                else
                begin
                    // clone q: copy its row, shorter length
                    we    = 1'b1;
                    waddr = count_reg + 1'b1;
                    wdata = rdata;
                    wdata[sa_pkg::LenLo +: IdxW] = plen_reg + 1'b1;
                    clone_next   = count_reg + 1'b1;
                    count_next   = count_reg + 1'b1;
                    made_next    = 1'b1;
                    linkcur_next = count_reg + 1'b1;
                    qrow_next    = rdata;
                    state_next   = sa_pkg::S_Q_WR;
                end
            end
            sa_pkg::S_Q_WR:
            begin
                we    = 1'b1;
                waddr = q_reg;
                wdata = qrow_reg;
                wdata[sa_pkg::LinkLo +: IdxW] = clone_reg;
                raddr      = pre_reg;
                state_next = sa_pkg::S_W2_CHK;
            end
            sa_pkg::S_W2_RD:
            begin
                raddr      = pre_reg;
                state_next = sa_pkg::S_W2_CHK;
            end
            sa_pkg::S_W2_CHK:
            begin
                if (tr == q_reg)
                begin
                    // redirect to the clone
                    we       = 1'b1;
                    waddr    = pre_reg;
                    wdata    = sa_pkg::set_trans(rdata, sym_reg, clone_reg);
                    pre_next = sa_pkg::get_link(rdata);
                    state_next = (sa_pkg::get_link(rdata) == '0) ? sa_pkg::S_FIN
                                                                  : sa_pkg::S_W2_RD;
                end
                else
                begin
                    state_next = sa_pkg::S_FIN;
                end
            end
            sa_pkg::S_FIN:
            begin
                we    = 1'b1;
                waddr = cur_reg;
                wdata = '0;
                wdata[sa_pkg::LenLo +: IdxW]  = curlen_reg;
                wdata[sa_pkg::LinkLo +: IdxW] = linkcur_reg;
                pend_next.new_state   = cur_reg;
                pend_next.new_length  = curlen_reg;
                pend_next.link_state  = linkcur_reg;
                pend_next.cloned      = made_reg;
                pend_next.clone_state = clone_reg;
                pend_next.state_count = count_reg;
                pend_next.full_res    = 1'b0;
                state_next = sa_pkg::S_OUT;
            end
            sa_pkg::S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    state_next     = sa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sa_pkg::S_CLEAR;
            clr_reg       <= '0;
            last_reg      <= sa_pkg::idx_t'(1);
            count_reg     <= sa_pkg::idx_t'(1);
            taken_reg     <= '0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
            made_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            last_reg      <= last_next;
            count_reg     <= count_next;
            taken_reg     <= taken_next;
            out_valid_reg <= out_valid_next;
            first_reg     <= first_next;
            made_reg      <= made_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pre_reg     <= pre_next;
        cur_reg     <= cur_next;
        q_reg       <= q_next;
        clone_reg   <= clone_next;
        curlen_reg  <= curlen_next;
        plen_reg    <= plen_next;
        linkcur_reg <= linkcur_next;
        sym_reg     <= sym_next;
        qrow_reg    <= qrow_next;
        pend_reg    <= pend_next;
        out_reg     <= out_next;
    end

    a_count_min: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_reg.state_count != '0))
        else $error("state count of a result is zero");

    a_walk_not_cur: assert property (@(posedge clk) disable iff (!rst_n)
        (we && (state_reg == sa_pkg::S_W1_CHK || state_reg == sa_pkg::S_W2_CHK))
        |-> (waddr != cur_reg))
        else $error("walk wrote the new state's row");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sa_pkg::S_CLEAR) |-> !s_tready)
        else $error("symbol taken during clearing pass");

endmodule
